// ===== hw/rtl/ptpm_pkg.sv =====
// shared types and constants for the packed trie prefix matcher
`default_nettype none
package ptpm_pkg;
   localparam int NODE_COUNT_DEF   = 4096;
   localparam int LONG_ENTRIES_DEF = 2048;
   localparam int MAX_HITS_DEF     = 16;

   localparam logic [7:0] FLAG_END         = 8'h80;
   localparam logic [7:0] FLAG_RIGHT       = 8'h40;
   localparam logic [7:0] FLAG_LONG        = 8'h20;
   localparam logic [7:0] FLAG_SPARE       = 8'h10;
   localparam logic [7:0] OFFSET_HIGH_MASK = 8'h07;
   localparam int         LOW_SPAN         = 256;

   typedef enum logic [1:0] {
      MODE_WRITE_NODE = 2'd0,
      MODE_WRITE_LONG = 2'd1,
      MODE_CHAR       = 2'd2,
      MODE_END        = 2'd3
   } mode_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [11:0] address;
      logic [7:0]  node_letter;
      logic [7:0]  node_control;
      logic [7:0]  node_offset_low;
      logic [11:0] long_offset;
      logic [7:0]  character;
   } req_type;

   typedef struct packed {
      logic        match_valid;
      logic [7:0]  match_offset;
      logic [11:0] match_node;
      logic [4:0]  match_count;
      logic        overflow;
      logic [11:0] exact_node;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_CUR,
      ST_WAIT_CUR,
      ST_RD_NEXT,
      ST_WAIT_NEXT,
      ST_RD_LONG,
      ST_WAIT_LONG,
      ST_FINISH,
      ST_EMIT_RD,
      ST_EMIT_WAIT,
      ST_EMIT_OUT
   } state_type;
endpackage
`default_nettype wire

// ===== hw/rtl/ptpm_if.sv =====
// valid/ready channel interfaces
`default_nettype none
interface ptpm_req_if import ptpm_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ptpm_rsp_if import ptpm_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ptpm_ram.sv =====
// generic single-port-write, single-read ram with registered read
`default_nettype none
module ptpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/ptpm_queue.sv =====
// front side: accepts transactions into a short queue
`default_nettype none
module ptpm_queue import ptpm_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  wire logic clock,
   input  wire logic reset,
   ptpm_req_if.sink  req,
   output logic      q_valid,
   output req_type   q_data,
   input  wire logic q_pop
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   req_type          slot_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             push;

   assign req.ready = (cnt_ff != (AW+1)'(DEPTH));
   assign push      = req.valid && req.ready;
   assign q_valid   = (cnt_ff != '0);
   assign q_data    = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      end
      if (q_pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      end
      if (push && !q_pop) begin
         cnt_in = cnt_ff + (AW+1)'(1);
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= req.data;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(DEPTH)) else $error("queue count out of range");
   a_push_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == (AW+1)'(DEPTH)) && !q_pop |=> cnt_ff == (AW+1)'(DEPTH))
      else $error("full queue lost entries");
endmodule
`default_nettype wire

// ===== hw/rtl/ptpm_engine.sv =====
// back side: trie walk, hit recording and result emission
`default_nettype none
module ptpm_engine import ptpm_pkg::*; #(
   parameter int NODE_COUNT   = NODE_COUNT_DEF,
   parameter int LONG_ENTRIES = LONG_ENTRIES_DEF,
   parameter int MAX_HITS     = MAX_HITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic longest_first,
   input  wire logic q_valid,
   input  req_type   q_data,
   output logic      q_pop,
   ptpm_rsp_if.source rsp
);
   localparam int NW = $clog2(NODE_COUNT);
   localparam int LW = (LONG_ENTRIES > 1) ? $clog2(LONG_ENTRIES) : 1;
   localparam int HW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
   localparam int CW = $clog2(MAX_HITS + 1);
   localparam int SW = NW + 1;

   state_type         st_ff, st_in;
   logic [NW-1:0]     cur_ff, cur_in;
   logic              alive_ff, alive_in;
   logic              matched_ff, matched_in;
   logic [7:0]        pos_ff, pos_in;
   logic [CW-1:0]     hcnt_ff, hcnt_in;
   logic              hovf_ff, hovf_in;
   logic [SW-1:0]     steps_ff, steps_in;
   logic [CW-1:0]     k_ff, k_in;
   rsp_type           out_ff, out_in;
   logic              ovalid_ff, ovalid_in;

   logic              n_we;
   logic [NW-1:0]     n_ra;
   logic [23:0]       n_rd;
   logic              l_we;
   logic [LW-1:0]     l_ra;
   logic [11:0]       l_rd;
   logic              h_we;
   logic [HW-1:0]     h_ra;
   logic [19:0]       h_rd;

   logic [7:0]        ctl;
   logic [10:0]       down_raw;
   logic [HW-1:0]     src;
   logic              nw_ok, lw_ok;
   logic [4:0]        cnt5;
   logic [11:0]       exact12;

   assign nw_ok = ({5'd0, q_data.address} < 17'(NODE_COUNT));
   assign lw_ok = ({1'b0, q_data.address} < 13'(LONG_ENTRIES));
   assign n_we  = q_valid && (st_ff == ST_IDLE) && (q_data.mode == MODE_WRITE_NODE) && nw_ok;
   assign l_we  = q_valid && (st_ff == ST_IDLE) && (q_data.mode == MODE_WRITE_LONG) && lw_ok;

   ptpm_ram #(.WIDTH(24), .DEPTH(NODE_COUNT)) u_nodes (
      .clock(clock), .wr_en(n_we), .wr_addr(NW'(q_data.address)),
      .wr_data({q_data.node_letter, q_data.node_control, q_data.node_offset_low}),
      .rd_addr(n_ra), .rd_data(n_rd));
   ptpm_ram #(.WIDTH(12), .DEPTH(LONG_ENTRIES)) u_long (
      .clock(clock), .wr_en(l_we), .wr_addr(LW'(q_data.address)),
      .wr_data(q_data.long_offset), .rd_addr(l_ra), .rd_data(l_rd));
   ptpm_ram #(.WIDTH(20), .DEPTH(MAX_HITS)) u_hits (
      .clock(clock), .wr_en(h_we), .wr_addr(HW'(hcnt_ff)),
      .wr_data({pos_ff, 12'(cur_ff)}), .rd_addr(h_ra), .rd_data(h_rd));

   assign ctl      = n_rd[15:8];
   assign down_raw = {ctl[2:0] & OFFSET_HIGH_MASK[2:0], n_rd[7:0]};
   assign src      = longest_first ? HW'(hcnt_ff - CW'(1) - k_ff) : HW'(k_ff);
   assign cnt5     = 5'(hcnt_ff);
   assign exact12  = matched_ff ? 12'(cur_ff) : 12'd0;
   assign rsp.valid = ovalid_ff;
   assign rsp.data  = out_ff;

   always_comb begin
      st_in      = st_ff;
      cur_in     = cur_ff;
      alive_in   = alive_ff;
      matched_in = matched_ff;
      pos_in     = pos_ff;
      hcnt_in    = hcnt_ff;
      hovf_in    = hovf_ff;
      steps_in   = steps_ff;
      k_in       = k_ff;
      out_in     = out_ff;
      ovalid_in  = ovalid_ff;
      q_pop      = 1'b0;
      n_ra       = cur_ff;
      l_ra       = LW'(down_raw);
      h_ra       = src;
      h_we       = 1'b0;
      if (rsp.ready) begin
         ovalid_in = 1'b0;
      end
      case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               case (q_data.mode)
                  MODE_WRITE_NODE, MODE_WRITE_LONG: q_pop = 1'b1;
                  MODE_CHAR: begin
                     if (alive_ff) begin
                        st_in = ST_WAIT_CUR;
                     end else begin
                        q_pop = 1'b1;
                        if (pos_ff != 8'd255) pos_in = pos_ff + 8'd1;
                     end
                  end
                  default: begin
                     k_in  = '0;
                     st_in = ST_EMIT_RD;
                  end
               endcase
            end
         end
         ST_WAIT_CUR: begin
            if ((ctl & FLAG_RIGHT) != 8'd0) begin
               cur_in   = cur_ff + NW'(1);
               n_ra     = cur_ff + NW'(1);
               steps_in = '0;
               st_in    = ST_WAIT_NEXT;
            end else begin
               matched_in = 1'b0;
               alive_in   = 1'b0;
               st_in      = ST_FINISH;
            end
         end
         ST_WAIT_NEXT: begin
            if (n_rd[23:16] == q_data.character) begin
               matched_in = 1'b1;
               if ((ctl & FLAG_END) != 8'd0) begin
                  if (hcnt_ff < CW'(MAX_HITS)) begin
                     h_we    = 1'b1;
                     hcnt_in = hcnt_ff + CW'(1);
                  end else begin
                     hovf_in = 1'b1;
                  end
               end
               st_in = ST_FINISH;
            end else if (steps_ff == SW'(NODE_COUNT)) begin
               matched_in = 1'b0;
               alive_in   = 1'b0;
               st_in      = ST_FINISH;
            end else if ((ctl & FLAG_LONG) != 8'd0) begin
               if ({5'd0, down_raw} < 16'(LONG_ENTRIES)) begin
                  st_in = ST_WAIT_LONG;
               end else begin
                  matched_in = 1'b0;
                  alive_in   = 1'b0;
                  st_in      = ST_FINISH;
               end
            end else if (down_raw == 11'd0) begin
               matched_in = 1'b0;
               alive_in   = 1'b0;
               st_in      = ST_FINISH;
            end else begin
               cur_in   = cur_ff + NW'(down_raw);
               n_ra     = cur_ff + NW'(down_raw);
               steps_in = steps_ff + SW'(1);
               st_in    = ST_WAIT_NEXT;
            end
         end
         ST_WAIT_LONG: begin
            if (l_rd == 12'd0) begin
               matched_in = 1'b0;
               alive_in   = 1'b0;
               st_in      = ST_FINISH;
            end else begin
               cur_in   = cur_ff + NW'(l_rd);
               n_ra     = cur_ff + NW'(l_rd);
               steps_in = steps_ff + SW'(1);
               st_in    = ST_WAIT_NEXT;
            end
         end
         ST_FINISH: begin
            q_pop = 1'b1;
            if (pos_ff != 8'd255) pos_in = pos_ff + 8'd1;
            st_in = ST_IDLE;
         end
         ST_EMIT_RD: begin
            st_in = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            st_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (!ovalid_ff || rsp.ready) begin
               ovalid_in          = 1'b1;
               out_in.match_count = cnt5;
               out_in.overflow    = hovf_ff;
               out_in.exact_node  = exact12;
               if (hcnt_ff == '0) begin
                  out_in.match_valid  = 1'b0;
                  out_in.match_offset = 8'd0;
                  out_in.match_node   = 12'd0;
                  out_in.last         = 1'b1;
               end else begin
                  out_in.match_valid  = 1'b1;
                  out_in.match_offset = h_rd[19:12];
                  out_in.match_node   = h_rd[11:0];
                  out_in.last         = (k_ff + CW'(1) == hcnt_ff);
               end
               if (hcnt_ff == '0 || k_ff + CW'(1) == hcnt_ff) begin
                  q_pop      = 1'b1;
                  cur_in     = '0;
                  alive_in   = 1'b1;
                  matched_in = 1'b0;
                  pos_in     = 8'd0;
                  hcnt_in    = '0;
                  hovf_in    = 1'b0;
                  st_in      = ST_IDLE;
               end else begin
                  k_in  = k_ff + CW'(1);
                  st_in = ST_EMIT_RD;
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
      if (st_ff == ST_EMIT_RD || st_ff == ST_EMIT_WAIT) begin
         h_ra = src;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= ST_IDLE;
         cur_ff     <= '0;
         alive_ff   <= 1'b1;
         matched_ff <= 1'b0;
         pos_ff     <= 8'd0;
         hcnt_ff    <= '0;
         hovf_ff    <= 1'b0;
         ovalid_ff  <= 1'b0;
      end else begin
         st_ff      <= st_in;
         cur_ff     <= cur_in;
         alive_ff   <= alive_in;
         matched_ff <= matched_in;
         pos_ff     <= pos_in;
         hcnt_ff    <= hcnt_in;
         hovf_ff    <= hovf_in;
         ovalid_ff  <= ovalid_in;
      end
      steps_ff <= steps_in;
      k_ff     <= k_in;
      out_ff   <= out_in;
   end

   a_hit_bound: assert property (@(posedge clock) disable iff (reset)
      hcnt_ff <= CW'(MAX_HITS)) else $error("hit count beyond capacity");
   a_dead_no_hit: assert property (@(posedge clock) disable iff (reset)
      !alive_ff |-> !h_we) else $error("hit recorded on failed walk");
   a_pop_state: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (st_ff == ST_IDLE || st_ff == ST_FINISH || st_ff == ST_EMIT_OUT))
      else $error("queue popped mid-walk");
   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      ovalid_ff && !rsp.ready |=> ovalid_ff && $stable(out_ff))
      else $error("pending result lost");
endmodule
`default_nettype wire

// ===== hw/rtl/packed_trie_prefix_matcher.sv =====
// top level of the packed trie prefix matcher
// Transactions (node write, long-offset write, character, end of string) enter a two-entry
// queue and are executed one at a time by a walk engine over the node memory. A write is
// popped directly from idle. A character whose right neighbor matches steps through current
// node read, right step, compare and pop, with a further node read per sibling hop and a
// long-offset table read then a node read per hop through the long-offset table; a character
// with no right neighbor goes from the current node read straight to the pop, and a character
// after a failed walk is popped directly. End of string emits each result through the hit
// buffer read, a wait state and the output register, waits while the output is stalled, and
// clears the per-string state. No clearing pass.
`default_nettype none
module packed_trie_prefix_matcher import ptpm_pkg::*; #(
   parameter int NODE_COUNT   = NODE_COUNT_DEF,
   parameter int LONG_ENTRIES = LONG_ENTRIES_DEF,
   parameter int MAX_HITS     = MAX_HITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_write_enable,
   input  wire logic csr_write_data,
   ptpm_req_if.sink   req,
   ptpm_rsp_if.source rsp
);
   logic    lf_ff;
   logic    q_valid;
   logic    q_pop;
   req_type q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         lf_ff <= 1'b0;
      end else if (csr_write_enable) begin
         lf_ff <= csr_write_data;
      end
   end

   ptpm_queue #(.DEPTH(2)) u_front (
      .clock(clock), .reset(reset), .req(req),
      .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop));

   ptpm_engine #(
      .NODE_COUNT(NODE_COUNT), .LONG_ENTRIES(LONG_ENTRIES), .MAX_HITS(MAX_HITS)
   ) u_back (
      .clock(clock), .reset(reset), .longest_first(lf_ff),
      .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop), .rsp(rsp));
endmodule
`default_nettype wire
